### rtl/pnorm_pkg.sv
// ----------------------------------------------------------------------------
// pnorm_pkg
// Shared types, request codes and configuration indexes for path_normalizer.
// ----------------------------------------------------------------------------
package pnorm_pkg;

	localparam int BUF_LEN_DEF = 256;
	localparam int CHAR_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT = 2'd2;

	// request modes
	localparam logic [1:0] MODE_BASE = 2'd0;
	localparam logic [1:0] MODE_NAME = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_NOP  = 2'd3;

	// result kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic [7:0]        index;
	} pnorm_in_t;

	typedef struct packed {
		logic              kind;
		logic              ok;
		logic [8:0]        path_len;
		logic [CHAR_W-1:0] data_char;
	} pnorm_out_t;

endpackage

### rtl/pnorm_ram.sv
// ----------------------------------------------------------------------------
// pnorm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pnorm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/path_normalizer.sv
// ----------------------------------------------------------------------------
// path_normalizer
// Streaming path canonicalizer: base and name characters build the resolved
// path in a character RAM; finish reports and read-back come out as results.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   request | in_valid, in_stall, in_data      | in
//   result  | out_valid, out_stall, out_data   | out
//   config  | cfg_wen, cfg_idx, cfg_data       | in
//
// Base and name characters are taken in ST_RUN; the first name character that
// needs a '/' after the base also passes through ST_SEP (second RAM write). A
// read goes through ST_READ (registered RAM read). A ".." component walks back
// through the RAM, one character at a time, on the single read port.
// Reset clears control state only; the RAM needs no clearing pass.
// in_stall is high while a multi-cycle request runs or a result is held.
// ----------------------------------------------------------------------------
module path_normalizer
	import pnorm_pkg::*;
#(
	parameter int BUF_LEN = BUF_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pnorm_in_t             in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pnorm_out_t            out_data,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(BUF_LEN);
	localparam int LW = $clog2(BUF_LEN + 1);
	localparam int SW = ((LW > CFG_DATA_W) ? LW : CFG_DATA_W) + 2;

	// sequencer states
	localparam logic [2:0] ST_RUN      = 3'd0;
	localparam logic [2:0] ST_SEP      = 3'd1;
	localparam logic [2:0] ST_READ     = 3'd2;
	localparam logic [2:0] ST_POP_RD   = 3'd3;
	localparam logic [2:0] ST_POP_WAIT = 3'd4;

	// path phases
	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_BASE      = 2'd1;
	localparam logic [1:0] PH_NAME      = 2'd2;
	localparam logic [1:0] PH_BASE_DONE = 2'd3;

	// dot pattern of the current component
	localparam logic [1:0] DOTS_EMPTY = 2'd0;
	localparam logic [1:0] DOTS_ONE   = 2'd1;
	localparam logic [1:0] DOTS_TWO   = 2'd2;
	localparam logic [1:0] DOTS_NONE  = 2'd3;

	logic [2:0]            st_q, st_d;
	logic [1:0]            phase_q, phase_d;
	logic [LW-1:0]         len_q, len_d;
	logic [LW-1:0]         comp_q, comp_d;
	logic [LW-1:0]         scan_q, scan_d;
	logic [1:0]            dots_q, dots_d;
	logic                  failed_q, failed_d;
	logic                  ovf_q, ovf_d;
	logic                  slash_q, slash_d;
	logic                  fin_q, fin_d;
	logic [AW-1:0]         sep_addr_q, sep_addr_d;
	logic                  rd_hit_q, rd_hit_d;

	logic [CFG_DATA_W-1:0] cap_q;
	logic                  chk_q;
	logic [CFG_DATA_W-1:0] lim_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [CHAR_W-1:0]     mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [CHAR_W-1:0]     mem_rdata;

	logic                  out_valid_q;
	pnorm_out_t            out_q;
	logic                  load;
	pnorm_out_t            load_word;

	logic                  acc;
	logic [SW-1:0]         eff_cap;

	logic                  is_slash, is_dot;
	logic [LW-1:0]         len_s, comp_s, comp_n, end_len, len_a;
	logic [1:0]            dots_s, dots_n, end_dots;
	logic                  failed_s, failed_n, need_sep;
	logic [SW-1:0]         pos;
	logic                  ch_we, do_end, do_pop, do_app;

	logic [LW-1:0]         rep_src, rep_len;
	logic                  rep_fail, rep_ok;
	pnorm_out_t            rep_word;
	logic                  pop_done, fin_now;

	pnorm_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (BUF_LEN)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_stall  = (st_q != ST_RUN) || (out_valid_q && out_stall);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign eff_cap = (SW'(cap_q) > SW'(BUF_LEN)) ? SW'(BUF_LEN) : SW'(cap_q);

	// name character: start of name, component tracking, end of component
	always_comb begin
		is_slash = in_data.ch == CH_SLASH;
		is_dot   = in_data.ch == CH_DOT;
		need_sep = 1'b0;
		if (phase_q != PH_NAME) begin
			len_s    = (phase_q == PH_IDLE || is_slash) ? '0 : len_q;
			comp_s   = '0;
			dots_s   = DOTS_EMPTY;
			failed_s = !is_slash && ovf_q && (phase_q != PH_IDLE);
			need_sep = !is_slash && !failed_s && (len_s != '0) && !slash_q;
			if (need_sep) begin
				len_s = len_s + LW'(1);
			end
		end else begin
			len_s    = len_q;
			comp_s   = comp_q;
			dots_s   = dots_q;
			failed_s = failed_q;
		end

		pos      = SW'(len_s) + SW'(comp_s);
		ch_we    = !failed_s && !is_slash && (pos < eff_cap);
		comp_n   = comp_s;
		dots_n   = dots_s;
		failed_n = failed_s;
		if (!failed_s && !is_slash) begin
			comp_n = comp_s + LW'(1);
			unique case (dots_s)
				DOTS_EMPTY: dots_n = is_dot ? DOTS_ONE : DOTS_NONE;
				DOTS_ONE:   dots_n = is_dot ? DOTS_TWO : DOTS_NONE;
				default:    dots_n = DOTS_NONE;
			endcase
			failed_n = (dots_n == DOTS_NONE) &&
				(SW'(len_s) + SW'(comp_n) + SW'(1) >= eff_cap);
		end

		end_len  = is_slash ? comp_s : comp_n;
		end_dots = is_slash ? dots_s : dots_n;
		do_end   = !failed_n && (is_slash || in_data.last);
		do_pop   = do_end && (end_len != '0) && (end_dots == DOTS_TWO);
		do_app   = do_end && (end_len != '0) && (end_dots == DOTS_NONE);
		len_a    = do_app ? (len_s + end_len + LW'(1)) : len_s;
	end

	// finish report; the stored path always ends in '/' here, so strip one
	always_comb begin
		rep_src  = (st_q == ST_RUN) ? len_a : scan_q;
		rep_fail = (st_q == ST_RUN) && failed_n;
		rep_len  = (rep_fail || rep_src == '0) ? '0 : (rep_src - LW'(1));
		rep_ok   = !rep_fail && (rep_len != '0) &&
			(!chk_q || (SW'(rep_len) <= SW'(lim_q)));
		rep_word.kind      = KIND_REPORT;
		rep_word.ok        = rep_ok;
		rep_word.path_len  = rep_ok ? 9'(rep_len) : '0;
		rep_word.data_char = '0;
	end

	always_comb begin
		st_d       = st_q;
		phase_d    = phase_q;
		len_d      = len_q;
		comp_d     = comp_q;
		dots_d     = dots_q;
		failed_d   = failed_q;
		ovf_d      = ovf_q;
		slash_d    = slash_q;
		scan_d     = scan_q;
		fin_d      = fin_q;
		sep_addr_d = sep_addr_q;
		rd_hit_d   = rd_hit_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_raddr  = '0;
		load       = 1'b0;
		load_word  = rep_word;
		pop_done   = 1'b0;
		fin_now    = 1'b0;

		unique case (st_q)
			ST_RUN: begin
				if (acc) begin
					unique case (in_data.mode)
						MODE_BASE: begin
							if (phase_q != PH_BASE) begin
								len_d    = '0;
								ovf_d    = 1'b0;
								failed_d = 1'b0;
								comp_d   = '0;
								dots_d   = DOTS_EMPTY;
							end
							phase_d = in_data.last ? PH_BASE_DONE : PH_BASE;
							if (!ovf_d) begin
								if (SW'(len_d) + SW'(2) >= eff_cap) begin
									ovf_d = 1'b1;
								end else begin
									mem_we    = 1'b1;
									mem_waddr = AW'(len_d);
									mem_wdata = in_data.ch;
									len_d     = len_d + LW'(1);
									slash_d   = is_slash;
								end
							end
						end
						MODE_NAME: begin
							phase_d  = PH_NAME;
							failed_d = failed_n;
							comp_d   = is_slash ? '0 : comp_n;
							dots_d   = is_slash ? DOTS_EMPTY : dots_n;
							len_d    = len_a;
							if (ch_we) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(pos);
								mem_wdata = in_data.ch;
							end else if (is_slash && do_app) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(SW'(len_s) + SW'(end_len));
								mem_wdata = CH_SLASH;
							end
							// separator after the base goes in on the next cycle
							if (need_sep) begin
								sep_addr_d = AW'(len_s - LW'(1));
								st_d       = ST_SEP;
							end
							if (do_pop) begin
								len_d  = len_s;
								comp_d = '0;
								dots_d = DOTS_EMPTY;
								scan_d = (len_s == '0) ? '0 : (len_s - LW'(1));
								fin_d  = in_data.last;
								st_d   = ST_POP_RD;
							end else if (in_data.last) begin
								fin_now = 1'b1;
							end
						end
						MODE_READ: begin
							rd_hit_d = (SW'(in_data.index) < SW'(len_q)) &&
								(SW'(in_data.index) < SW'(BUF_LEN));
							mem_raddr = AW'(in_data.index);
							st_d      = ST_READ;
						end
						MODE_NOP: begin
						end
					endcase
				end
			end
			ST_SEP: begin
				mem_we    = 1'b1;
				mem_waddr = sep_addr_q;
				mem_wdata = CH_SLASH;
				st_d      = ST_RUN;
			end
			ST_READ: begin
				load                = 1'b1;
				load_word.kind      = KIND_DATA;
				load_word.ok        = 1'b0;
				load_word.path_len  = '0;
				load_word.data_char = rd_hit_q ? mem_rdata : '0;
				st_d                = ST_RUN;
			end
			ST_POP_RD: begin
				if (scan_q == '0) begin
					pop_done = 1'b1;
				end else begin
					mem_raddr = AW'(scan_q - LW'(1));
					st_d      = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				if (mem_rdata == CH_SLASH) begin
					pop_done = 1'b1;
				end else begin
					scan_d = scan_q - LW'(1);
					st_d   = ST_POP_RD;
				end
			end
			default: begin
				st_d = ST_RUN;
			end
		endcase

		if (pop_done) begin
			st_d    = ST_RUN;
			len_d   = scan_q;
			fin_d   = 1'b0;
			fin_now = fin_q;
		end

		if (fin_now) begin
			load      = 1'b1;
			load_word = rep_word;
			phase_d   = PH_IDLE;
			ovf_d     = 1'b0;
			comp_d    = '0;
			dots_d    = DOTS_EMPTY;
			failed_d  = 1'b0;
			len_d     = rep_ok ? rep_len : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_RUN;
			phase_q     <= PH_IDLE;
			len_q       <= '0;
			comp_q      <= '0;
			scan_q      <= '0;
			dots_q      <= DOTS_EMPTY;
			failed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			slash_q     <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cap_q       <= CFG_DATA_W'(256);
			chk_q       <= 1'b0;
			lim_q       <= CFG_DATA_W'(64);
		end else begin
			st_q     <= st_d;
			phase_q  <= phase_d;
			len_q    <= len_d;
			comp_q   <= comp_d;
			scan_q   <= scan_d;
			dots_q   <= dots_d;
			failed_q <= failed_d;
			ovf_q    <= ovf_d;
			slash_q  <= slash_d;
			fin_q    <= fin_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wen) begin
				unique case (cfg_idx)
					CFG_CAPACITY:   cap_q <= cfg_data;
					CFG_CHECK:      chk_q <= cfg_data[0];
					CFG_NAME_LIMIT: lim_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		sep_addr_q <= sep_addr_d;
		rd_hit_q   <= rd_hit_d;
		if (load) begin
			out_q <= load_word;
		end
	end

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_READ |-> !out_valid_q)
		else $error("read data arrives while a result is still held");

	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_READ |=> out_valid_q)
		else $error("read request produced no result");

	a_pop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POP_RD || st_q == ST_POP_WAIT) |-> !mem_we)
		else $error("store written during component pop");

	a_pop_scan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_POP_WAIT |-> scan_q != '0)
		else $error("pop scan waiting on read below the start of the path");

endmodule
